// File: design/hcv_pkg.sv
package hcv_pkg;

    // Fraction bits of the sine and cosine values.
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int TRIG_SH = 16 - TRIG_FRAC_BITS;
    localparam int TRIG_HALF = (1 << TRIG_SH) >> 1;

    // Offset, rotation and product widths.
    localparam int DXY_W = 9;
    localparam int PP_W = DXY_W + TRIG_W;
    localparam int ROT_W = PP_W + 1;
    localparam int BASE_W = 16;
    localparam int PROD_W = BASE_W + ROT_W;
    localparam int NUM_W = 41;

    // Length: root of (dx^2 + dy^2) << 16, one root bit per stage.
    localparam int D2_W = 17;
    localparam int SQ_STAGES = (D2_W + 16 + 1) / 2;
    localparam int DEN_W = SQ_STAGES;
    localparam int DIV_STAGES = NUM_W;

    // Output rounding offsets in units of 1/256.
    localparam int OFS_X = 141;
    localparam int OFS_Y = 397;

    // Quarter-wave sine table, round(sin(d) * 2^16) for d = 0..90.
    localparam logic [16:0] SIN_Q16 [91] = '{
        17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
        17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
        17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
        17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
        17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
        17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
        17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
        17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
        17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
        17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // Sine of an angle 0..449 degrees in Q2.TRIG_FRAC_BITS.
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [8:0] ang);
        logic [8:0] a;
        logic [6:0] d;
        logic neg;
        logic [17:0] rnd;
        logic [TRIG_W-1:0] mag;
        a = (ang >= 9'd360) ? ang - 9'd360 : ang;
        neg = 1'b0;
        if (a <= 9'd90) begin
            d = a[6:0];
        end else if (a <= 9'd180) begin
            d = 7'(9'd180 - a);
        end else if (a <= 9'd270) begin
            d = 7'(a - 9'd180);
            neg = 1'b1;
        end else begin
            d = 7'(9'd360 - a);
            neg = 1'b1;
        end
        rnd = ({1'b0, SIN_Q16[d]} + 18'(TRIG_HALF)) >> TRIG_SH;
        mag = TRIG_W'(rnd);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// File: design/hcv_sqrt.sv
module hcv_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [hcv_pkg::D2_W-1:0]     i_d2,
    output logic [hcv_pkg::DEN_W-1:0]    o_root
);
    import hcv_pkg::*;

    localparam int VAL_W = 2 * SQ_STAGES;
    localparam int REM_W = SQ_STAGES + 3;

    logic [VAL_W-1:0]     r_val  [SQ_STAGES];
    logic [REM_W-1:0]     r_rem  [SQ_STAGES];
    logic [SQ_STAGES-1:0] r_root [SQ_STAGES];
    logic [VAL_W-1:0]     n_val  [SQ_STAGES];
    logic [REM_W-1:0]     n_rem  [SQ_STAGES];
    logic [SQ_STAGES-1:0] n_root [SQ_STAGES];

    // One root bit per stage: bring down two radicand bits and try a subtract.
    always_comb begin
        logic [VAL_W-1:0]     s_val;
        logic [REM_W-1:0]     s_rem;
        logic [SQ_STAGES-1:0] s_root;
        logic [REM_W-1:0]     sh;
        logic [REM_W-1:0]     trial;
        for (int j = 0; j < SQ_STAGES; j++) begin
            if (j == 0) begin
                s_val  = VAL_W'({i_d2, 16'd0});
                s_rem  = '0;
                s_root = '0;
            end else begin
                s_val  = r_val[j-1];
                s_rem  = r_rem[j-1];
                s_root = r_root[j-1];
            end
            sh    = {s_rem[REM_W-3:0], s_val[VAL_W-1:VAL_W-2]};
            trial = REM_W'({s_root, 2'b01});
            n_val[j] = {s_val[VAL_W-3:0], 2'b00};
            if (sh >= trial) begin
                n_rem[j]  = sh - trial;
                n_root[j] = {s_root[SQ_STAGES-2:0], 1'b1};
            end else begin
                n_rem[j]  = sh;
                n_root[j] = {s_root[SQ_STAGES-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < SQ_STAGES; j++) begin
                r_val[j]  <= n_val[j];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

// File: design/hcv_div.sv
module hcv_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [hcv_pkg::NUM_W-1:0]   i_num,
    input  logic [hcv_pkg::DEN_W-1:0]   i_den,
    output logic [hcv_pkg::NUM_W-1:0]   o_quo
);
    import hcv_pkg::*;

    logic [NUM_W-1:0] r_q   [DIV_STAGES];
    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [NUM_W-1:0] n_q   [DIV_STAGES];
    logic [DEN_W-1:0] n_rem [DIV_STAGES];

    // Restoring division: the numerator shifts out at the top while quotient
    // bits fill in at the bottom, one bit per stage.
    always_comb begin
        logic [NUM_W-1:0] s_q;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [DEN_W:0]   sh;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                s_q   = i_num;
                s_rem = '0;
                s_den = i_den;
            end else begin
                s_q   = r_q[j-1];
                s_rem = r_rem[j-1];
                s_den = r_den[j-1];
            end
            sh = {s_rem, s_q[NUM_W-1]};
            if (sh >= {1'b0, s_den}) begin
                n_rem[j] = DEN_W'(sh - {1'b0, s_den});
                n_q[j]   = {s_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[j] = DEN_W'(sh);
                n_q[j]   = {s_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int j = 1; j < DIV_STAGES; j++) r_den[j] <= r_den[j-1];
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_q[j]   <= n_q[j];
                r_rem[j] <= n_rem[j];
            end
        end
    end

    assign o_quo = r_q[DIV_STAGES-1];

endmodule

// File: design/heading_compensated_velocity_vector.sv
// Heading-compensated velocity vector.
// Slave channel: one beat per command carrying goal point, current position,
// heading in whole degrees and base speed. Master channel: one beat per
// command with the rotated, scaled velocity and an at-goal flag in tuser.
// The offset is rotated by 45 degrees minus heading, divided by its length
// and scaled by the base speed, then truncated and saturated to int16.
// The accepting edge loads the first front stage. After it come one more
// front stage, then a 17-stage square-root pipeline that produces one root
// bit per stage while the rotation and scaling wait beside it, then a
// 41-stage divider that produces one quotient bit per stage, and the output
// register. Throughput is one beat per cycle while the receiver keeps up.
// All stages move together; when the receiver stalls with a result waiting,
// the whole pipeline holds and tready on the slave side drops, so nothing
// is lost or repeated. Reset clears only the valid bits; the pipeline is
// empty and ready for a beat in the cycle after reset is released.
module heading_compensated_velocity_vector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: goal_x[7:0], goal_y[15:8], current_x[23:16],
    // current_y[31:24], heading_deg[40:32], base_speed[56:41], zero pad.
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: vel_x[15:0], vel_y[31:16].
    output logic [31:0] m_axis_tdata,
    // Fields from bit 0: at_goal[0].
    output logic [0:0]  m_axis_tuser
);
    import hcv_pkg::*;

    localparam int ALIGN_LEN = SQ_STAGES - 3;

    typedef struct packed {
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
    } t_align;

    logic en;

    // Stage 1: offsets and table lookups.
    logic                      r1_valid;
    logic signed [DXY_W-1:0]   r1_dx, r1_dy;
    logic signed [TRIG_W-1:0]  r1_s, r1_c;
    logic signed [BASE_W-1:0]  r1_base;
    // Stage 2: partial products and squared length.
    logic                      r2_valid;
    logic signed [PP_W-1:0]    r2_dxc, r2_dys, r2_dyc, r2_dxs;
    logic [D2_W-1:0]           r2_d2;
    logic signed [BASE_W-1:0]  r2_base;
    logic                      r2_zero;
    // Stage 3: rotated offset.
    logic                      r3_valid;
    logic signed [ROT_W-1:0]   r3_rx, r3_ry;
    logic signed [BASE_W-1:0]  r3_base;
    logic                      r3_zero;
    // Stage 4: scaled products.
    logic                      r4_valid;
    logic signed [PROD_W-1:0]  r4_px, r4_py;
    logic                      r4_zero;
    // Stage 5 onward: magnitudes wait for the length.
    logic                      r_al_valid [ALIGN_LEN+1];
    t_align                    r_al       [ALIGN_LEN+1];
    logic                      r_dv_valid [DIV_STAGES];
    t_side                     r_dv       [DIV_STAGES];
    // Output register.
    logic                      r_out_valid;
    logic [31:0]               r_out_data;
    logic                      r_out_goal;

    logic signed [DXY_W-1:0]   n1_dx, n1_dy;
    logic signed [10:0]        n1_ang;
    logic [8:0]                n1_a;
    logic [PROD_W-1:0]         n5_ax, n5_ay;
    t_align                    n5;
    logic [DEN_W-1:0]          root;
    logic [NUM_W-1:0]          quo_x, quo_y;
    logic signed [15:0]        n_vx, n_vy;

    assign en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Offset at nine bits and angle reduced to 0..359.
    always_comb begin
        n1_dx  = DXY_W'($signed(s_axis_tdata[7:0])) - DXY_W'($signed(s_axis_tdata[23:16]));
        n1_dy  = DXY_W'($signed(s_axis_tdata[15:8])) - DXY_W'($signed(s_axis_tdata[31:24]));
        n1_ang = 11'sd45 - 11'($signed(s_axis_tdata[40:32]));
        if (n1_ang < 0) begin
            n1_a = 9'(n1_ang + 11'sd360);
        end else begin
            n1_a = 9'(n1_ang);
        end
    end

    // Magnitudes with the division's fixed scale folded in.
    always_comb begin
        n5_ax = r4_px[PROD_W-1] ? PROD_W'(-r4_px) : PROD_W'(r4_px);
        n5_ay = r4_py[PROD_W-1] ? PROD_W'(-r4_py) : PROD_W'(r4_py);
        n5.side.zero  = r4_zero;
        n5.side.neg_x = r4_px[PROD_W-1];
        n5.side.neg_y = r4_py[PROD_W-1];
        n5.num_x = NUM_W'(n5_ax) << TRIG_SH;
        n5.num_y = NUM_W'(n5_ay) << TRIG_SH;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j <= ALIGN_LEN; j++) r_al_valid[j] <= 1'b0;
            for (int j = 0; j < DIV_STAGES; j++) r_dv_valid[j] <= 1'b0;
        end else if (en) begin
            r1_valid <= s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r_al_valid[0] <= r4_valid;
            for (int j = 1; j <= ALIGN_LEN; j++) r_al_valid[j] <= r_al_valid[j-1];
            r_dv_valid[0] <= r_al_valid[ALIGN_LEN];
            for (int j = 1; j < DIV_STAGES; j++) r_dv_valid[j] <= r_dv_valid[j-1];
            r_out_valid <= r_dv_valid[DIV_STAGES-1];
        end
    end

    // Front stages.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
            r1_s    <= sin_deg(n1_a);
            r1_c    <= sin_deg(n1_a + 9'd90);
            r1_base <= $signed(s_axis_tdata[56:41]);

            r2_dxc  <= r1_dx * r1_c;
            r2_dys  <= r1_dy * r1_s;
            r2_dyc  <= r1_dy * r1_c;
            r2_dxs  <= r1_dx * r1_s;
            r2_d2   <= D2_W'(18'(r1_dx * r1_dx) + 18'(r1_dy * r1_dy));
            r2_base <= r1_base;
            r2_zero <= (r1_dx == 0) && (r1_dy == 0);

            r3_rx   <= ROT_W'(r2_dxc) + ROT_W'(r2_dys);
            r3_ry   <= ROT_W'(r2_dyc) - ROT_W'(r2_dxs);
            r3_base <= r2_base;
            r3_zero <= r2_zero;

            r4_px   <= r3_base * r3_rx;
            r4_py   <= r3_base * r3_ry;
            r4_zero <= r3_zero;

            r_al[0] <= n5;
            for (int j = 1; j <= ALIGN_LEN; j++) r_al[j] <= r_al[j-1];
            r_dv[0] <= r_al[ALIGN_LEN].side;
            for (int j = 1; j < DIV_STAGES; j++) r_dv[j] <= r_dv[j-1];
        end
    end

    hcv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_d2   (r2_d2),
        .o_root (root)
    );

    hcv_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_al[ALIGN_LEN].num_x),
        .i_den (root),
        .o_quo (quo_x)
    );

    hcv_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_al[ALIGN_LEN].num_y),
        .i_den (root),
        .o_quo (quo_y)
    );

    // Apply sign, add offset, truncate toward zero by 256 and saturate.
    function automatic logic signed [15:0] finish(input logic [NUM_W-1:0] quo,
                                                  input logic neg, input int ofs);
        logic signed [NUM_W+1:0] q;
        logic signed [NUM_W+1:0] t;
        logic signed [NUM_W+1:0] d;
        q = $signed({2'b00, quo});
        if (neg) q = -q;
        t = q + (NUM_W+2)'(ofs);
        if (t < 0) begin
            d = (t + (NUM_W+2)'(255)) >>> 8;
        end else begin
            d = t >>> 8;
        end
        if (d > (NUM_W+2)'(32767)) begin
            return 16'sd32767;
        end else if (d < -(NUM_W+2)'(32768)) begin
            return -16'sd32768;
        end
        return 16'(d);
    endfunction

    always_comb begin
        n_vx = finish(quo_x, r_dv[DIV_STAGES-1].neg_x, OFS_X);
        n_vy = finish(quo_y, r_dv[DIV_STAGES-1].neg_y, OFS_Y);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_goal <= r_dv[DIV_STAGES-1].zero;
            if (r_dv[DIV_STAGES-1].zero) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {n_vy, n_vx};
            end
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_goal;

endmodule

// File: design/hcv_checker.sv
module hcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A waiting result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // The pipeline holds as a whole while a result waits.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // An at-goal result carries zero velocity.
    a_goal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("at-goal beat with nonzero velocity");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind heading_compensated_velocity_vector hcv_checker u_hcv_checker (.*);

// File: sim/heading_compensated_velocity_vector_tb.sv
`timescale 1ns / 1ps

module heading_compensated_velocity_vector_tb;
    import hcv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PIPE_LATENCY = 61;
    localparam int RANDOM_CMDS = 1950;

    // One predicted velocity beat.
    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic               at_goal;
    } t_velocity;

    // Predicts the velocity of each accepted command and checks result beats in order.
    class velocity_scoreboard;
        t_velocity pending[$];
        int mismatches = 0;
        int checked = 0;
        int goal_hits = 0;

        // Sine of 0..359 degrees in Q2.14, signed by quadrant.
        function automatic longint trig_q14(int a);
            int d;
            longint m;
            a = a % 360;
            if (a <= 90) d = a;
            else if (a <= 180) d = 180 - a;
            else if (a <= 270) d = a - 180;
            else d = 360 - a;
            m = longint'((SIN_Q16[d] + TRIG_HALF) >> TRIG_SH);
            return (a > 180) ? -m : m;
        endfunction

        // Bitwise integer square root.
        function automatic longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 40;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic signed [15:0] scale_comp(longint base, longint rot,
                                                          longint den, longint ofs);
            longint q;
            longint v;
            q = (base * rot * 65536) / den;
            v = (q + ofs) / 256;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
        endfunction

        function void note_command(logic [63:0] d);
            longint dx, dy, hd, base, ang, s, c, rx, ry, den;
            t_velocity e;
            dx = longint'($signed(d[7:0])) - longint'($signed(d[23:16]));
            dy = longint'($signed(d[15:8])) - longint'($signed(d[31:24]));
            hd = longint'($signed(d[40:32]));
            base = longint'($signed(d[56:41]));
            if (dx == 0 && dy == 0) begin
                e = '{vel_x: 16'sd0, vel_y: 16'sd0, at_goal: 1'b1};
            end else begin
                ang = 45 - hd;
                while (ang < 0) ang += 360;
                ang = ang % 360;
                s = trig_q14(int'(ang));
                c = trig_q14(int'(ang) + 90);
                rx = dx * c + dy * s;
                ry = dy * c - dx * s;
                den = longint'(int_root(64'(dx * dx + dy * dy) << 16) << TRIG_FRAC_BITS);
                e.vel_x = scale_comp(base, rx, den, OFS_X);
                e.vel_y = scale_comp(base, ry, den, OFS_Y);
                e.at_goal = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_velocity(logic [31:0] data, logic flag);
            t_velocity e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: vel_x %0d vel_y %0d at_goal %0b",
                             $signed(data[15:0]), $signed(data[31:16]), flag);
                return;
            end
            e = pending.pop_front();
            if (e.at_goal) goal_hits++;
            if (data[15:0] !== e.vel_x || data[31:16] !== e.vel_y || flag !== e.at_goal) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: vel_x %0d/%0d vel_y %0d/%0d at_goal %0b/%0b (exp/got)",
                             e.vel_x, $signed(data[15:0]), e.vel_y, $signed(data[31:16]),
                             e.at_goal, flag);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    velocity_scoreboard sb = new();
    bit allow_gaps = 1'b1;
    int sent = 0;
    int idle_cycles = 0;

    heading_compensated_velocity_vector uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one command beat and waits until it is taken.
    task automatic send_cmd(logic signed [7:0] gx, logic signed [7:0] gy,
                            logic signed [7:0] cx, logic signed [7:0] cy,
                            logic signed [8:0] hd, logic signed [15:0] bs);
        logic [63:0] d;
        d = {7'd0, bs, hd, cy, cx, gy, gx};
        if (allow_gaps && $urandom_range(99) < 5) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(d);
        sent++;
    endtask

    // Receiver: random stalls, one long hold-off so the pipeline backs up.
    initial begin
        int cyc;
        m_axis_tready <= 1'b0;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 800) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if (cyc > 1500 && cyc < 2500) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(99) >= 10);
        end
    end

    // Result beat checks.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_velocity(m_axis_tdata, m_axis_tuser[0]);
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", sb.pending.size());
                $display("heading_compensated_velocity_vector_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        logic signed [7:0] gx, gy, cx, cy;
        logic signed [8:0] hd;
        logic signed [15:0] bs;
        int sel;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero offset, coordinate and speed extremes, heading wrap.
        send_cmd(8'sd10, -8'sd5, 8'sd10, -8'sd5, 9'sd0, 16'sd1000);
        send_cmd(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 9'sd90, 16'sd32767);
        send_cmd(8'sd127, 8'sd127, -8'sd128, -8'sd128, 9'sd0, 16'sd32767);
        send_cmd(-8'sd128, -8'sd128, 8'sd127, 8'sd127, 9'sd0, -16'sd32768);
        send_cmd(8'sd127, -8'sd128, -8'sd128, 8'sd127, 9'sd45, 16'sd32767);
        send_cmd(8'sd1, 8'sd0, 8'sd0, 8'sd0, 9'sd45, 16'sd256);
        send_cmd(8'sd0, 8'sd1, 8'sd0, 8'sd0, -9'sd45, 16'sd256);
        send_cmd(8'sd3, 8'sd4, 8'sd0, 8'sd0, 9'sd180, 16'sd500);
        send_cmd(8'sd3, 8'sd4, 8'sd0, 8'sd0, -9'sd180, 16'sd500);
        send_cmd(8'sd3, 8'sd4, 8'sd0, 8'sd0, 9'sd255, 16'sd500);
        send_cmd(8'sd3, 8'sd4, 8'sd0, 8'sd0, -9'sd256, 16'sd500);
        send_cmd(-8'sd7, 8'sd2, 8'sd0, 8'sd0, 9'sd135, 16'sd0);
        send_cmd(8'sd0, -8'sd1, 8'sd0, 8'sd0, -9'sd135, -16'sd1);
        send_cmd(8'sd1, 8'sd1, 8'sd0, 8'sd0, 9'sd1, 16'sd32767);
        send_cmd(-8'sd1, 8'sd0, 8'sd0, 8'sd0, 9'sd0, -16'sd32768);
        send_cmd(8'sd100, -8'sd20, -8'sd3, 8'sd60, -9'sd90, 16'sd1);

        // Random commands; a middle stretch runs without sender gaps.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            allow_gaps = !(n >= 600 && n < 1000);
            sel = $urandom_range(99);
            gx = 8'($urandom);
            gy = 8'($urandom);
            cx = 8'($urandom);
            cy = 8'($urandom);
            if (sel < 10) begin
                cx = gx;
                cy = gy;
            end else if (sel < 30) begin
                cx = 8'(gx - 8'($urandom_range(6)) + 8'sd3);
                cy = 8'(gy - 8'($urandom_range(6)) + 8'sd3);
            end
            if ($urandom_range(99) < 80) hd = 9'($signed($urandom_range(360)) - 180);
            else hd = 9'($urandom);
            bs = 16'($urandom);
            if ($urandom_range(99) < 5) bs = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
            else if ($urandom_range(99) < 30) bs = 16'($signed($urandom_range(2000)) - 1000);
            send_cmd(gx, gy, cx, cy, hd, bs);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);
        if (sb.pending.size() != 0) sb.mismatches++;

        $display("run covered %0d commands, %0d result beats checked, %0d at goal",
                 sent, sb.checked, sb.goal_hits);
        $display("with random stalls on both channels and one long receiver hold-off");
        if (sb.mismatches == 0) begin
            $display("heading_compensated_velocity_vector_tb: clean");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("heading_compensated_velocity_vector_tb: errors");
        end
        $finish;
    end

endmodule
